@@ hdl/gtoe_pkg.sv @@
// Shared constants, types and elaboration-time tables for the geodetic to ECEF converter
`default_nettype none
package gtoe_pkg;

	localparam int CORDIC_STAGES = 32;
	localparam int TRIG_FRACTION_BITS = 30;
	localparam int GUARD_BITS = 16;

	localparam int ANGLE_W = 32;
	localparam int HEIGHT_W = 28;
	localparam int OUT_W = 34;
	localparam int AXIS_W = 33;
	localparam int ECC_W = 31;
	localparam int TRIG_W = TRIG_FRACTION_BITS + 2;

	// CORDIC datapath word: x/y in Q60, z with 2^61 = pi
	localparam int CW = 64;
	localparam int STAGE_IDX_W = $clog2(CORDIC_STAGES);

	localparam int SQRT_STEPS = 32;
	localparam int SQRT_IDX_W = 5;
	localparam int SQRT_W = 64;
	localparam int ROOT_W = 32;

	localparam int QUOT_W = 34;
	localparam int DIV_STEPS = QUOT_W;
	localparam int NUM_W = 64;
	localparam int REM_W = 32;

	localparam int RMUL_STAGES = 5;
	localparam int RMUL_A_W = 56;

	localparam logic [63:0] GAIN_Q32 = 64'h0000_0000_9B74_EDA8;
	localparam logic [63:0] TWO_OVER_PI_Q64 = 64'hA2F9_836E_4E44_152A;

	localparam logic [AXIS_W-1:0] AXIS_RESET = 33'd6378137000;
	localparam logic [ECC_W-1:0] ECC_RESET = 31'd28752143;

	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = AXIS_W;
	localparam logic [CFG_IDX_W-1:0] CFG_SEMI_MAJOR = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ECC_SQ = 4'd1;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 flip;
	} cordic_t;

	typedef struct packed {
		logic [SQRT_W-1:0] v;
		logic [SQRT_W-1:0] res;
	} sqrt_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [NUM_W-1:0]  numq;
		logic [ROOT_W-1:0] dvsr;
	} div_t;

	// shift-subtract division, elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], num[b]};
			if (r >= {1'b0, den}) begin
				r = r - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// atan(2^-i) from the arctangent series, scaled so 2^61 = pi
	function automatic logic [63:0] atan_units(input int unsigned i);
		logic [63:0]  sum;
		logic [63:0]  term;
		logic [127:0] prod;
		int           e;
		sum = '0;
		if (i == 0) return 64'd1 << 59;
		for (int k = 0; k < 64; k++) begin
			e = 62 - int'(i) * (2 * k + 1);
			if (e >= 0) begin
				term = udiv64(64'd1 << e, 64'(2 * k + 1));
				if (k[0]) sum = sum - term;
				else sum = sum + term;
			end
		end
		prod = {64'd0, sum} * {64'd0, TWO_OVER_PI_Q64};
		return {2'b00, prod[127:66]};
	endfunction

endpackage
`default_nettype wire

@@ hdl/geodetic_to_ecef.sv @@
// Top level: geodetic latitude/longitude/height to earth-centred X/Y/Z pipeline
//
// channel  | handshake               | payload
// ---------+-------------------------+------------------------------------------
// cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data (register write)
// pos      | pos_valid / pos_ready   | latitude_angle, longitude_angle, height_mm
// ecef     | ecef_valid / ecef_ready | x_mm, y_mm, z_mm
//
// Fully pipelined: one request per cycle while no result is held, through 32 CORDIC
// cells, 32 root cells, 34 divider cells and 17 arithmetic stages.
// cfg_ready is always high; writes land in the next cycle.
// Reset loads the WGS-84 axis and eccentricity and empties the pipeline.
// A held result freezes every stage, and pos_ready drops with it.
`default_nettype none
module geodetic_to_ecef (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [gtoe_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [gtoe_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                    pos_valid,
	output logic                                    pos_ready,
	input  logic signed [gtoe_pkg::ANGLE_W-1:0]     latitude_angle,
	input  logic signed [gtoe_pkg::ANGLE_W-1:0]     longitude_angle,
	input  logic signed [gtoe_pkg::HEIGHT_W-1:0]    height_mm,
	output logic                                    ecef_valid,
	input  logic                                    ecef_ready,
	output logic signed [gtoe_pkg::OUT_W-1:0]       x_mm,
	output logic signed [gtoe_pkg::OUT_W-1:0]       y_mm,
	output logic signed [gtoe_pkg::OUT_W-1:0]       z_mm
);
	localparam int CS = gtoe_pkg::CORDIC_STAGES;
	localparam int STW = gtoe_pkg::STAGE_IDX_W;
	localparam int CW = gtoe_pkg::CW;
	localparam int F = gtoe_pkg::TRIG_FRACTION_BITS;
	localparam int G = gtoe_pkg::GUARD_BITS;
	localparam int TW = gtoe_pkg::TRIG_W;
	localparam int AW = gtoe_pkg::ANGLE_W;
	localparam int HW = gtoe_pkg::HEIGHT_W;
	localparam int XW = gtoe_pkg::AXIS_W;
	localparam int EW = gtoe_pkg::ECC_W;
	localparam int NS = gtoe_pkg::SQRT_STEPS;
	localparam int SIW = gtoe_pkg::SQRT_IDX_W;
	localparam int SW = gtoe_pkg::SQRT_W;
	localparam int RTW = gtoe_pkg::ROOT_W;
	localparam int QW = gtoe_pkg::QUOT_W;
	localparam int ND = gtoe_pkg::DIV_STEPS;
	localparam int NW = gtoe_pkg::NUM_W;
	localparam int RW = gtoe_pkg::REM_W;
	localparam int MAW = gtoe_pkg::RMUL_A_W;

	localparam int DEPTH = 1 + CS + 5 + NS + 1 + ND + 5 + gtoe_pkg::RMUL_STAGES;

	// angle to CORDIC z: 2^31 = pi becomes 2^61 = pi
	localparam int Z_SH = 30;
	localparam logic signed [AW:0] QUARTER = (AW + 1)'(1) <<< (AW - 2);
	localparam logic signed [AW:0] HALF_TURN = (AW + 1)'(1) <<< (AW - 1);
	localparam logic signed [CW-1:0] X0 = $signed(gtoe_pkg::GAIN_Q32 << 28);

	localparam int TRIG_SH = 60 - F;
	localparam logic signed [CW-1:0] TRIG_RND = CW'(1) <<< (TRIG_SH - 1);
	localparam logic signed [CW-1:0] TRIG_ONE = CW'(1) <<< F;

	localparam int SQW = 2 * TW;
	localparam int SQ_SH = 2 * F - 32;
	localparam logic [SQW-1:0] SQ_HALF = (SQW'(1) << SQ_SH) >> 1;
	localparam logic [SQW-1:0] ONE_Q32_W = SQW'(1) << 32;

	localparam int NPW = QW + 2;
	localparam int OMW = 33;
	localparam int PTW = NPW + TW;
	localparam int PMW = QW + OMW;
	localparam int T_SH = F - G;
	localparam int M_SH = 32 - G;
	localparam logic [PTW-1:0] T_HALF = (PTW'(1) << T_SH) >> 1;
	localparam logic [PMW-1:0] M_HALF = (PMW'(1) << M_SH) >> 1;
	localparam int TMW = PTW - T_SH;
	localparam int MMW = PMW - M_SH;

	typedef struct packed {
		logic signed [TW-1:0] cl;
		logic signed [TW-1:0] sl;
		logic signed [TW-1:0] co;
		logic signed [TW-1:0] so;
		logic signed [HW-1:0] h;
	} side_t;

	function automatic gtoe_pkg::cordic_t cordic_start(input logic signed [AW-1:0] ang);
		logic signed [AW:0] af;
		gtoe_pkg::cordic_t  c;
		af = {ang[AW-1], ang};
		c.flip = 1'b0;
		if (af > QUARTER) begin
			af = af - HALF_TURN;
			c.flip = 1'b1;
		end else if (af < -QUARTER) begin
			af = af + HALF_TURN;
			c.flip = 1'b1;
		end
		c.x = X0;
		c.y = '0;
		c.z = CW'(af) <<< Z_SH;
		return c;
	endfunction

	// negate on fold, round half up to Q2.F, clamp to +-1
	function automatic logic signed [TW-1:0] to_trig(input logic signed [CW-1:0] v,
			input logic flip);
		logic signed [CW-1:0] s;
		logic signed [CW-1:0] r;
		s = flip ? (TRIG_RND - v) : (v + TRIG_RND);
		r = s >>> TRIG_SH;
		if (r > TRIG_ONE) r = TRIG_ONE;
		if (r < -TRIG_ONE) r = -TRIG_ONE;
		return TW'(r);
	endfunction

	logic            adv;
	logic [DEPTH-1:0] vld_q;
	logic [XW-1:0]   axis_q;
	logic [EW-1:0]   ecc_q;

	gtoe_pkg::cordic_t    lat_s1;
	gtoe_pkg::cordic_t    lon_s1;
	logic signed [HW-1:0] h_s1;
	gtoe_pkg::cordic_t    lat_c [0:CS];
	gtoe_pkg::cordic_t    lon_c [0:CS];
	logic signed [HW-1:0] h_dly_q [0:CS-1];

	side_t           side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	side_t           side_s8, side_s9, side_s10, side_s11, side_s12;
	side_t           side_sq_q [0:NS-1];
	side_t           side_dv_q [0:ND-1];

	logic [SQW-1:0]  sq_s3;
	logic [32:0]     s2_s4;
	logic [63:0]     prod_s5;
	gtoe_pkg::sqrt_t sq_in_s6;
	gtoe_pkg::sqrt_t sqrt_c [0:NS];
	gtoe_pkg::div_t  div_s7;
	gtoe_pkg::div_t  div_c [0:ND];

	logic [SQW-1:0]  s2_raw;
	logic [64:0]     p_rnd;
	logic [32:0]     w_val;
	logic [RTW-1:0]  root;
	logic [NW-1:0]   num;
	logic [QW-1:0]   quot;

	logic signed [NPW-1:0] nph_s8;
	logic [QW-1:0]         n_s8, n_s9;
	logic [OMW-1:0]        omc_s8, omc_s9;
	logic [NPW-1:0]        nmag_s9;
	logic [TW-1:0]         clmag_s9;
	logic                  tneg_s9, tneg_s10, tneg_s11;
	logic [PTW-1:0]        pt_s10;
	logic [PMW-1:0]        pm_s10;
	logic [PTW-1:0]        t_sum;
	logic [PMW-1:0]        m_sum;
	logic [TMW-1:0]        tmag_s11;
	logic [MMW-1:0]        mmag_s11;
	logic signed [MAW-1:0] t_s12;
	logic signed [MAW-1:0] m_s12;

	assign cfg_ready = 1'b1;
	assign adv = !vld_q[DEPTH-1] || ecef_ready;
	assign pos_ready = adv;
	assign ecef_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= gtoe_pkg::AXIS_RESET;
			ecc_q <= gtoe_pkg::ECC_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				gtoe_pkg::CFG_SEMI_MAJOR: axis_q <= cfg_data[XW-1:0];
				gtoe_pkg::CFG_ECC_SQ:     ecc_q <= cfg_data[EW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], pos_valid};
		end
	end

	// CORDIC section
	always_ff @(posedge clk) begin
		if (adv) begin
			lat_s1 <= cordic_start(latitude_angle);
			lon_s1 <= cordic_start(longitude_angle);
			h_s1 <= height_mm;
			h_dly_q[0] <= h_s1;
			for (int i = 1; i < CS; i++) h_dly_q[i] <= h_dly_q[i-1];
		end
	end

	assign lat_c[0] = lat_s1;
	assign lon_c[0] = lon_s1;

	genvar g;
	generate
		for (g = 0; g < CS; g++) begin : g_cordic
			localparam logic [CW-1:0] ATAN = gtoe_pkg::atan_units(g);
			gtoe_cordic_cell u_lat (
				.clk   (clk),
				.en    (adv),
				.shift (STW'(g)),
				.atan  (ATAN),
				.din   (lat_c[g]),
				.dout  (lat_c[g+1])
			);
			gtoe_cordic_cell u_lon (
				.clk   (clk),
				.en    (adv),
				.shift (STW'(g)),
				.atan  (ATAN),
				.din   (lon_c[g]),
				.dout  (lon_c[g+1])
			);
		end
	endgenerate

	// sin^2 lat and the radicand 1 - e2 sin^2 lat, shifted to Q62
	assign s2_raw = (sq_s3 + SQ_HALF) >> SQ_SH;
	assign p_rnd = {1'b0, prod_s5} + (65'(1) << 31);
	assign w_val = 33'(ONE_Q32_W) - p_rnd[64:32];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2.cl <= to_trig(lat_c[CS].x, lat_c[CS].flip);
			side_s2.sl <= to_trig(lat_c[CS].y, lat_c[CS].flip);
			side_s2.co <= to_trig(lon_c[CS].x, lon_c[CS].flip);
			side_s2.so <= to_trig(lon_c[CS].y, lon_c[CS].flip);
			side_s2.h <= h_dly_q[CS-1];

			sq_s3 <= side_s2.sl * side_s2.sl;
			side_s3 <= side_s2;

			s2_s4 <= (s2_raw > ONE_Q32_W) ? 33'(ONE_Q32_W) : s2_raw[32:0];
			side_s4 <= side_s3;

			prod_s5 <= ecc_q * s2_s4;
			side_s5 <= side_s4;

			sq_in_s6.v <= {1'b0, w_val, 30'd0};
			sq_in_s6.res <= '0;
			side_s6 <= side_s5;
		end
	end

	// square root section
	assign sqrt_c[0] = sq_in_s6;

	generate
		for (g = 0; g < NS; g++) begin : g_sqrt
			gtoe_sqrt_cell u_cell (
				.clk  (clk),
				.en   (adv),
				.step (SIW'(NS - 1 - g)),
				.din  (sqrt_c[g]),
				.dout (sqrt_c[g+1])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (adv) begin
			side_sq_q[0] <= side_s6;
			for (int i = 1; i < NS; i++) side_sq_q[i] <= side_sq_q[i-1];
		end
	end

	// N = (a * 2^31 + r/2) / r
	assign root = sqrt_c[NS].res[RTW-1:0];
	assign num = {axis_q, 31'd0} + NW'(root >> 1);

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s7.rem <= RW'(num[NW-1:QW]);
			div_s7.numq <= {num[QW-1:0], {(NW - QW){1'b0}}};
			div_s7.dvsr <= (root == '0) ? RTW'(1) : root;
			side_s7 <= side_sq_q[NS-1];
		end
	end

	assign div_c[0] = div_s7;

	generate
		for (g = 0; g < ND; g++) begin : g_div
			gtoe_div_cell u_cell (
				.clk  (clk),
				.en   (adv),
				.din  (div_c[g]),
				.dout (div_c[g+1])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (adv) begin
			side_dv_q[0] <= side_s7;
			for (int i = 1; i < ND; i++) side_dv_q[i] <= side_dv_q[i-1];
		end
	end

	// (N+h)cos(lat) and N(1-e2)+h with guard bits
	assign quot = div_c[ND].numq[QW-1:0];
	assign t_sum = pt_s10 + T_HALF;
	assign m_sum = pm_s10 + M_HALF;

	always_ff @(posedge clk) begin
		if (adv) begin
			nph_s8 <= $signed({2'b00, quot}) + side_dv_q[ND-1].h;
			n_s8 <= quot;
			omc_s8 <= 33'(ONE_Q32_W) - {2'b00, ecc_q};
			side_s8 <= side_dv_q[ND-1];

			nmag_s9 <= nph_s8[NPW-1] ? $unsigned(-nph_s8) : $unsigned(nph_s8);
			clmag_s9 <= side_s8.cl[TW-1] ? $unsigned(-side_s8.cl) : $unsigned(side_s8.cl);
			tneg_s9 <= nph_s8[NPW-1] ^ side_s8.cl[TW-1];
			n_s9 <= n_s8;
			omc_s9 <= omc_s8;
			side_s9 <= side_s8;

			pt_s10 <= nmag_s9 * clmag_s9;
			pm_s10 <= n_s9 * omc_s9;
			tneg_s10 <= tneg_s9;
			side_s10 <= side_s9;

			tmag_s11 <= t_sum[PTW-1:T_SH];
			mmag_s11 <= m_sum[PMW-1:M_SH];
			tneg_s11 <= tneg_s10;
			side_s11 <= side_s10;

			t_s12 <= tneg_s11 ? -$signed({1'b0, tmag_s11}) : $signed({1'b0, tmag_s11});
			m_s12 <= $signed({1'b0, mmag_s11}) + (MAW'(side_s11.h) <<< G);
			side_s12 <= side_s11;
		end
	end

	gtoe_rmul u_mul_x (
		.clk (clk),
		.en  (adv),
		.a   (t_s12),
		.b   (side_s12.co),
		.p   (x_mm)
	);

	gtoe_rmul u_mul_y (
		.clk (clk),
		.en  (adv),
		.a   (t_s12),
		.b   (side_s12.so),
		.p   (y_mm)
	);

	gtoe_rmul u_mul_z (
		.clk (clk),
		.en  (adv),
		.a   (m_s12),
		.b   (side_s12.sl),
		.p   (z_mm)
	);

endmodule
`default_nettype wire

@@ hdl/gtoe_cordic_cell.sv @@
// One rotation-mode CORDIC micro-rotation with its output register
`default_nettype none
module gtoe_cordic_cell (
	input  logic                               clk,
	input  logic                               en,
	input  logic [gtoe_pkg::STAGE_IDX_W-1:0]   shift,
	input  logic [gtoe_pkg::CW-1:0]            atan,
	input  gtoe_pkg::cordic_t                  din,
	output gtoe_pkg::cordic_t                  dout
);
	localparam int CW = gtoe_pkg::CW;

	gtoe_pkg::cordic_t    nxt;
	gtoe_pkg::cordic_t    rot_q;
	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;

	always_comb begin
		xs = $signed(din.x) >>> shift;
		ys = $signed(din.y) >>> shift;
		nxt = din;
		if (!din.z[CW-1]) begin
			nxt.x = din.x - ys;
			nxt.y = din.y + xs;
			nxt.z = din.z - $signed(atan);
		end else begin
			nxt.x = din.x + ys;
			nxt.y = din.y - xs;
			nxt.z = din.z + $signed(atan);
		end
	end

	always_ff @(posedge clk) begin
		if (en) rot_q <= nxt;
	end

	assign dout = rot_q;
endmodule
`default_nettype wire

@@ hdl/gtoe_sqrt_cell.sv @@
// One digit step of the integer square root with its output register
`default_nettype none
module gtoe_sqrt_cell (
	input  logic                              clk,
	input  logic                              en,
	input  logic [gtoe_pkg::SQRT_IDX_W-1:0]   step,
	input  gtoe_pkg::sqrt_t                   din,
	output gtoe_pkg::sqrt_t                   dout
);
	localparam int SW = gtoe_pkg::SQRT_W;

	gtoe_pkg::sqrt_t nxt;
	gtoe_pkg::sqrt_t root_q;
	logic [SW-1:0]   bitv;
	logic [SW-1:0]   trial;

	always_comb begin
		bitv = SW'(1) << {step, 1'b0};
		trial = din.res + bitv;
		nxt = din;
		if (din.v >= trial) begin
			nxt.v = din.v - trial;
			nxt.res = (din.res >> 1) + bitv;
		end else begin
			nxt.res = din.res >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) root_q <= nxt;
	end

	assign dout = root_q;
endmodule
`default_nettype wire

@@ hdl/gtoe_div_cell.sv @@
// One quotient bit of the restoring divider with its output register
`default_nettype none
module gtoe_div_cell (
	input  logic           clk,
	input  logic           en,
	input  gtoe_pkg::div_t din,
	output gtoe_pkg::div_t dout
);
	localparam int RW = gtoe_pkg::REM_W;
	localparam int NW = gtoe_pkg::NUM_W;

	gtoe_pkg::div_t nxt;
	gtoe_pkg::div_t quo_q;
	logic [RW:0]    trial;
	logic [RW:0]    diff;
	logic           qb;

	always_comb begin
		trial = {din.rem, din.numq[NW-1]};
		diff = trial - {1'b0, din.dvsr};
		qb = (trial >= {1'b0, din.dvsr});
		nxt = din;
		nxt.rem = qb ? diff[RW-1:0] : trial[RW-1:0];
		nxt.numq = {din.numq[NW-2:0], qb};
	end

	always_ff @(posedge clk) begin
		if (en) quo_q <= nxt;
	end

	assign dout = quo_q;
endmodule
`default_nettype wire

@@ hdl/gtoe_rmul.sv @@
// Split signed multiply by a trig value, rounded and saturated to the output width
`default_nettype none
module gtoe_rmul (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [gtoe_pkg::RMUL_A_W-1:0]  a,
	input  logic signed [gtoe_pkg::TRIG_W-1:0]    b,
	output logic signed [gtoe_pkg::OUT_W-1:0]     p
);
	localparam int AW = gtoe_pkg::RMUL_A_W;
	localparam int TW = gtoe_pkg::TRIG_W;
	localparam int LW = AW / 2;
	localparam int HW = AW - LW;
	localparam int PW = AW + TW;
	localparam int FS = gtoe_pkg::TRIG_FRACTION_BITS + gtoe_pkg::GUARD_BITS;
	localparam int MW = PW - FS;
	localparam int OW = gtoe_pkg::OUT_W;
	localparam logic [PW-1:0] HALF = PW'(1) << (FS - 1);
	localparam logic [OW-1:0] POS_LIM = (OW'(1) << (OW - 1)) - OW'(1);
	localparam logic [OW-1:0] NEG_LIM = OW'(1) << (OW - 1);

	logic [AW-1:0]    amag_s1;
	logic [TW-1:0]    bmag_s1;
	logic             neg_s1;
	logic [LW+TW-1:0] plo_s2;
	logic [HW+TW-1:0] phi_s2;
	logic             neg_s2;
	logic [MW-1:0]    mag_s3;
	logic             neg_s3;
	logic [OW-1:0]    smag_s4;
	logic             neg_s4;
	logic [OW-1:0]    p_s5;
	logic [PW-1:0]    sum;
	logic [OW-1:0]    lim;

	assign sum = (PW'(phi_s2) << LW) + PW'(plo_s2) + HALF;
	assign lim = neg_s3 ? NEG_LIM : POS_LIM;

	always_ff @(posedge clk) begin
		if (en) begin
			amag_s1 <= a[AW-1] ? $unsigned(-a) : $unsigned(a);
			bmag_s1 <= b[TW-1] ? $unsigned(-b) : $unsigned(b);
			neg_s1 <= a[AW-1] ^ b[TW-1];

			plo_s2 <= amag_s1[LW-1:0] * bmag_s1;
			phi_s2 <= amag_s1[AW-1:LW] * bmag_s1;
			neg_s2 <= neg_s1;

			mag_s3 <= sum[PW-1:FS];
			neg_s3 <= neg_s2;

			smag_s4 <= (mag_s3 > MW'(lim)) ? lim : OW'(mag_s3);
			neg_s4 <= neg_s3;

			p_s5 <= neg_s4 ? (~smag_s4 + OW'(1)) : smag_s4;
		end
	end

	assign p = $signed(p_s5);
endmodule
`default_nettype wire

@@ dv/ecef_checker.sv @@
// Checker for the geodetic to ECEF converter: bit-true coordinate prediction and result compare
module ecef_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [gtoe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gtoe_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 pos_valid,
	input  logic                                 pos_ready,
	input  logic signed [gtoe_pkg::ANGLE_W-1:0]  latitude_angle,
	input  logic signed [gtoe_pkg::ANGLE_W-1:0]  longitude_angle,
	input  logic signed [gtoe_pkg::HEIGHT_W-1:0] height_mm,
	input  logic                                 ecef_valid,
	input  logic                                 ecef_ready,
	input  logic signed [gtoe_pkg::OUT_W-1:0]    x_mm,
	input  logic signed [gtoe_pkg::OUT_W-1:0]    y_mm,
	input  logic signed [gtoe_pkg::OUT_W-1:0]    z_mm,
	output int                                   errors,
	output int                                   pending
);
	import gtoe_pkg::*;

	typedef struct {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic signed [OUT_W-1:0] z;
	} ecef_pos_t;

	localparam longint OUT_HI = (longint'(1) << (OUT_W - 1)) - 1;
	localparam longint OUT_LO = -(longint'(1) << (OUT_W - 1));

	logic [AXIS_W-1:0] axis_mm;
	logic [ECC_W-1:0]  ecc_q32;
	longint            arctan_tbl [CORDIC_STAGES];
	ecef_pos_t         ecef_expected [$];

	assign pending = ecef_expected.size();

	// round(a*b / 2^n), ties away from zero
	function automatic longint rnd_mul(input longint a, input longint b, input int n);
		logic         neg;
		logic [63:0]  ua, ub, m;
		logic [127:0] prod;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		prod = {64'd0, ua} * {64'd0, ub};
		if (n > 0) prod = prod + (128'd1 << (n - 1));
		m = prod >> n;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint arctan_step(input int i);
		longint       acc;
		logic [63:0]  term;
		logic [127:0] prod;
		int           e;
		if (i == 0) return longint'(1) << 59;
		acc = 0;
		for (int k = 0; k < 64; k++) begin
			e = 62 - i * (2 * k + 1);
			if (e >= 0) begin
				term = (64'd1 << e) / 64'(2 * k + 1);
				if (k % 2) acc = acc - longint'(term);
				else acc = acc + longint'(term);
			end
		end
		prod = {64'd0, 64'(acc)} * {64'd0, TWO_OVER_PI_Q64};
		return longint'(prod[127:66]);
	endfunction

	function automatic longint trig_round(input longint v);
		longint r;
		r = (v + (longint'(1) << (59 - TRIG_FRACTION_BITS))) >>> (60 - TRIG_FRACTION_BITS);
		if (r > (longint'(1) << TRIG_FRACTION_BITS)) r = longint'(1) << TRIG_FRACTION_BITS;
		if (r < -(longint'(1) << TRIG_FRACTION_BITS)) r = -(longint'(1) << TRIG_FRACTION_BITS);
		return r;
	endfunction

	task automatic rotate(input longint ang, output longint c, output longint s);
		logic   flip;
		longint x, y, z, xs, ys;
		flip = 1'b0;
		// fold into +-pi/2, undo by negating
		if (ang > (longint'(1) << 30)) begin
			ang -= longint'(1) << 31;
			flip = 1'b1;
		end else if (ang < -(longint'(1) << 30)) begin
			ang += longint'(1) << 31;
			flip = 1'b1;
		end
		z = ang <<< 30;
		x = longint'(GAIN_Q32) <<< 28;
		y = 0;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= arctan_tbl[i];
			end else begin
				x += ys; y -= xs; z += arctan_tbl[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = trig_round(x);
		s = trig_round(y);
	endtask

	function automatic logic [63:0] int_root(input logic [63:0] v);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else res = res >> 1;
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic signed [OUT_W-1:0] clip(input longint v);
		if (v > OUT_HI) v = OUT_HI;
		if (v < OUT_LO) v = OUT_LO;
		return v[OUT_W-1:0];
	endfunction

	task automatic convert_position(input longint lat, input longint lon, input longint h,
			output ecef_pos_t r);
		longint      cl, sl, co, so, s2, nph, t, m;
		logic [63:0] p, w, root, n;
		rotate(lat, cl, sl);
		rotate(lon, co, so);
		s2 = rnd_mul(sl, sl, 2 * TRIG_FRACTION_BITS - 32);
		if (s2 > (longint'(1) << 32)) s2 = longint'(1) << 32;
		p = (64'(ecc_q32) * 64'(s2) + (64'd1 << 31)) >> 32;
		w = (64'd1 << 32) - p;
		root = int_root(w << 30);
		if (root == 0) root = 1;
		n = ((64'(axis_mm) << 31) + (root >> 1)) / root;
		nph = longint'(n) + h;
		t = rnd_mul(nph, cl, TRIG_FRACTION_BITS - GUARD_BITS);
		m = rnd_mul(longint'(n), (longint'(1) << 32) - longint'(ecc_q32), 32 - GUARD_BITS)
			+ (h <<< GUARD_BITS);
		r.x = clip(rnd_mul(t, co, TRIG_FRACTION_BITS + GUARD_BITS));
		r.y = clip(rnd_mul(t, so, TRIG_FRACTION_BITS + GUARD_BITS));
		r.z = clip(rnd_mul(m, sl, TRIG_FRACTION_BITS + GUARD_BITS));
	endtask

	initial begin
		for (int i = 0; i < CORDIC_STAGES; i++) arctan_tbl[i] = arctan_step(i);
	end

	always @(posedge clk or negedge arst_n) begin
		ecef_pos_t exp_pos;
		if (!arst_n) begin
			axis_mm <= AXIS_RESET;
			ecc_q32 <= ECC_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SEMI_MAJOR) axis_mm <= cfg_data[AXIS_W-1:0];
				else if (cfg_index == CFG_ECC_SQ) ecc_q32 <= cfg_data[ECC_W-1:0];
			end
			if (pos_valid && pos_ready) begin
				convert_position(longint'(latitude_angle), longint'(longitude_angle),
					longint'(height_mm), exp_pos);
				ecef_expected.push_back(exp_pos);
			end
			if (ecef_valid && ecef_ready) begin
				if (ecef_expected.size() == 0) begin
					errors++;
					$display("%0t: unexpected result x=%0d y=%0d z=%0d", $time, x_mm, y_mm, z_mm);
				end else begin
					exp_pos = ecef_expected.pop_front();
					if (x_mm !== exp_pos.x || y_mm !== exp_pos.y || z_mm !== exp_pos.z) begin
						errors++;
						$display("%0t: mismatch expected x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
							$time, exp_pos.x, exp_pos.y, exp_pos.z, x_mm, y_mm, z_mm);
					end
				end
			end
		end
	end
endmodule

@@ dv/tb_geodetic_to_ecef.sv @@
// Testbench top for the geodetic to ECEF converter: stimulus, flow control and verdict
module tb_geodetic_to_ecef;
	import gtoe_pkg::*;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [CFG_DATA_W-1:0]       cfg_data = '0;
	logic                        pos_valid = 1'b0;
	logic                        pos_ready;
	logic signed [ANGLE_W-1:0]   latitude_angle = '0;
	logic signed [ANGLE_W-1:0]   longitude_angle = '0;
	logic signed [HEIGHT_W-1:0]  height_mm = '0;
	logic                        ecef_valid;
	logic                        ecef_ready = 1'b0;
	logic signed [OUT_W-1:0]     x_mm, y_mm, z_mm;
	int                          errors, pending;
	logic                        no_gaps = 1'b0;

	localparam int DRAIN_CYCLES = 130;

	always #2 clk = ~clk;

	geodetic_to_ecef DUT (.*);

	ecef_checker u_checker (.*);

	initial begin
		#4000000;
		$display("DONE: errors detected");
		$finish;
	end

	// result side: random stall per request
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 7);
			if (stall) begin
				ecef_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			ecef_ready <= 1'b1;
			do @(posedge clk); while (!ecef_valid);
		end
	end

	task automatic send_pos(input logic [ANGLE_W-1:0] lat, input logic [ANGLE_W-1:0] lon,
			input logic [HEIGHT_W-1:0] h);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		if (gap) begin
			pos_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pos_valid <= 1'b1;
		latitude_angle <= lat;
		longitude_angle <= lon;
		height_mm <= h;
		do @(posedge clk); while (!pos_ready);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		pos_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_batch(input int count);
		logic [ANGLE_W-1:0]  lat;
		logic [HEIGHT_W-1:0] h;
		for (int i = 0; i < count; i++) begin
			if (i % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
			// mostly legal latitudes and heights, some anywhere in the field
			if ($urandom_range(0, 9) == 0) lat = $urandom;
			else lat = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
			if ($urandom_range(0, 9) == 0) h = $urandom;
			else h = $urandom_range(0, 101000000) - 1000000;
			send_pos(lat, $urandom, h);
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, quadrant folding, out-of-range latitude
		send_pos(32'sd0, 32'sd0, 28'sd0);
		send_pos(32'sh4000_0000, 32'sd0, 28'sd0);
		send_pos(-32'sh4000_0000, 32'sd0, 28'sd100000000);
		send_pos(32'sd0, 32'sh8000_0000, -28'sd1000000);
		send_pos(32'sd0, 32'sh7FFF_FFFF, 28'sd0);
		send_pos(32'sd0, 32'sh4000_0000, 28'sd0);
		send_pos(32'sd0, 32'sh4000_0001, 28'sd0);
		send_pos(32'sd0, -32'sh4000_0000, 28'sd0);
		send_pos(32'sd0, -32'sh4000_0001, 28'sd0);
		send_pos(32'sh2000_0000, 32'sh6000_0000, 28'sh7FF_FFFF);
		send_pos(-32'sh2000_0000, -32'sh6000_0000, 28'sh800_0000);
		send_pos(32'sh7FFF_FFFF, 32'sh1234_5678, 28'sd12345);
		send_pos(32'sh8000_0000, -32'sh1234_5678, -28'sd12345);
		send_pos(32'sh4000_0001, 32'sd1, 28'sd1);
		send_pos(-32'sh4000_0001, -32'sd1, -28'sd1);
		send_pos(32'sh5555_5555, 32'shAAAA_AAAA, 28'sh555_5555);
		send_pos(32'shAAAA_AAAA, 32'sh5555_5555, 28'shAAA_AAAA);
		send_pos(32'sh3FFF_FFFF, 32'sh2000_0000, 28'sd50000000);
		random_batch(300);

		write_reg(CFG_SEMI_MAJOR, 33'd6000000000);
		write_reg(CFG_ECC_SQ, 33'd0);
		random_batch(300);

		write_reg(CFG_SEMI_MAJOR, 33'd7000000000);
		write_reg(CFG_ECC_SQ, 33'd1073741824);
		random_batch(300);

		// outside stated ranges: outputs saturate; unknown index ignored
		write_reg(CFG_SEMI_MAJOR, 33'h1_FFFF_FFFF);
		write_reg(CFG_ECC_SQ, 33'h0_7FFF_FFFF);
		write_reg(4'hF, 33'h0_0000_1234);
		write_reg(4'h2, 33'h1_5555_5555);
		random_batch(300);

		write_reg(CFG_SEMI_MAJOR, 33'd6000000000 + 33'($urandom_range(0, 1000000000)));
		write_reg(CFG_ECC_SQ, 33'($urandom_range(0, 1073741824)));
		random_batch(300);

		pos_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule

@@ sim.f @@
hdl/gtoe_pkg.sv
hdl/gtoe_cordic_cell.sv
hdl/gtoe_sqrt_cell.sv
hdl/gtoe_div_cell.sv
hdl/gtoe_rmul.sv
hdl/geodetic_to_ecef.sv
dv/ecef_checker.sv
dv/tb_geodetic_to_ecef.sv
